FILE: sv/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg: shared types and constants for the vertex normal accumulator
// Payload structs, operation codes and the fixed-point widths used by the
// accumulator datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package vna_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int VTX_AW       = $clog2(MAX_VERTICES);
   localparam int POS_W        = 32;
   localparam int ACC_W        = 24;
   localparam int NRM_W        = 16;
   localparam int CNT_W        = 11;
   localparam int EDGE_W       = 33;
   localparam int MUL_W        = 31;
   localparam int PROD_W       = 2 * MUL_W;
   localparam int VEC_W        = 62;
   localparam int SQ_W         = 64;
   localparam int LEN_W        = 32;
   localparam int NUM_W        = 47;
   localparam int QUO_W        = 15;

   localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(MAX_VERTICES);

   localparam logic signed [ACC_W:0] ACC_MAX = (ACC_W+1)'(8388607);
   localparam logic signed [ACC_W:0] ACC_MIN = -(ACC_W+1)'(8388608);

   localparam logic [1:0] KIND_WRITE    = 2'd0;
   localparam logic [1:0] KIND_TRIANGLE = 2'd1;
   localparam logic [1:0] KIND_READ     = 2'd2;
   localparam logic [1:0] KIND_CLEAR    = 2'd3;

   typedef struct packed {
      logic [1:0]               kind;
      logic [9:0]               vertex_index;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  pos_z;
      logic [9:0]               corner_a;
      logic [9:0]               corner_b;
      logic [9:0]               corner_c;
   } req_payload_type;

   typedef struct packed {
      logic signed [NRM_W-1:0]  normal_x;
      logic signed [NRM_W-1:0]  normal_y;
      logic signed [NRM_W-1:0]  normal_z;
      logic                     degenerate;
   } rsp_payload_type;

endpackage

`default_nettype wire

FILE: sv/vertex_normal_accumulator.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator: per-vertex normal averaging in fixed point
// Position store, saturating normal accumulators and one shared multiplier,
// square-root and divider sequence that forms unit normals in Q1.14.
// ----------------------------------------------------------------------------
//  channel   dir   handshake             payload
//  req       in    req_valid/req_ready   req_payload (req_payload_type)
//  rsp       out   rsp_valid/rsp_ready   rsp_payload (rsp_payload_type)
//  csr       in    csr_valid/csr_ready   csr_data (vertex_count)
//
//  Triangles and reads run a 32-step square root and three 15-step divisions
//  on one shared divider. Clear writes one entry a cycle.
//  After reset the same clearing pass runs before req_ready.
//  A finished read waits in the output register; the block stalls only when
//  a second read result is ready before the first has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_normal_accumulator (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  vna_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output vna_pkg::rsp_payload_type  rsp_payload,
   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  wire [vna_pkg::CNT_W-1:0]  csr_data
);
   import vna_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_FETCH, ST_EDGE, ST_ESHIFT, ST_CROSS, ST_ZCHK,
      ST_NORM, ST_SQR, ST_SQRT, ST_DIVLD, ST_DIV, ST_URD, ST_UWR,
      ST_ARD, ST_ALD, ST_PUT
   } state_type;

   state_type               state_ff;
   req_payload_type         req_ff;
   logic [CNT_W-1:0]        vcount_ff;
   logic [2:0]              step_ff;
   logic [1:0]              comp_ff;
   logic [VTX_AW-1:0]       clr_addr_ff;
   logic signed [POS_W-1:0] cpos_ff [0:2][0:2];
   logic [EDGE_W-1:0]       edge_mag_ff [0:5];
   logic [5:0]              edge_neg_ff;
   logic signed [PROD_W-1:0] mul_ff;
   logic signed [SQ_W-1:0]  cross_ff;
   logic [VEC_W-1:0]        vec_mag_ff [0:2];
   logic [2:0]              vec_neg_ff;
   logic [SQ_W-1:0]         rem_ff;
   logic [SQ_W-1:0]         root_ff;
   logic [SQ_W-1:0]         bit_ff;
   logic [LEN_W-1:0]        len_ff;
   logic [NUM_W-1:0]        num_ff;
   logic [QUO_W-1:0]        quo_ff;
   logic [3:0]              qbit_ff;
   logic signed [NRM_W-1:0] nrm_ff [0:2];
   logic                    degen_ff;
   logic                    rsp_valid_ff;
   rsp_payload_type         rsp_payload_ff;

   // memories
   logic [3*POS_W-1:0] pos_mem [MAX_VERTICES];
   logic [3*ACC_W-1:0] acc_mem [MAX_VERTICES];
   logic [3*POS_W-1:0] pos_rd_ff;
   logic [3*ACC_W-1:0] acc_rd_ff;

   logic               req_xfer;
   logic               pos_we;
   logic [VTX_AW-1:0]  pos_raddr;
   logic               acc_we;
   logic [VTX_AW-1:0]  acc_waddr;
   logic [VTX_AW-1:0]  acc_raddr;
   logic [3*ACC_W-1:0] acc_wdata;
   logic [VTX_AW-1:0]  cur_corner;
   logic               corner_live;

   logic signed [EDGE_W-1:0] edge_val [0:5];
   logic signed [MUL_W-1:0]  edge_s [0:5];
   logic                     edge_big;
   logic signed [MUL_W-1:0]  mul_a;
   logic signed [MUL_W-1:0]  mul_b;
   logic signed [SQ_W-1:0]   cross_diff;
   logic [SQ_W-1:0]          cross_abs;
   logic [VEC_W-1:0]         vec_or;
   logic [SQ_W-1:0]          sqrt_trial;
   logic                     sqrt_hit;
   logic [SQ_W-1:0]          root_next;
   logic [NUM_W-1:0]         div_trial;
   logic                     div_hit;
   logic [QUO_W-1:0]         quo_next;
   logic [VEC_W-1:0]         comp_mag;
   logic                     comp_neg;
   logic signed [ACC_W-1:0]  acc_cur [0:2];

   function automatic logic signed [ACC_W-1:0] sat_add(
      input logic signed [ACC_W-1:0] a,
      input logic signed [NRM_W-1:0] d
   );
      logic signed [ACC_W:0] s;
      s = (ACC_W+1)'(a) + (ACC_W+1)'(d);
      if (s > ACC_MAX) s = ACC_MAX;
      if (s < ACC_MIN) s = ACC_MIN;
      return s[ACC_W-1:0];
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ---- address and data selection ----
   always_comb begin
      case (comp_ff)
         2'd0:    cur_corner = req_ff.corner_a;
         2'd1:    cur_corner = req_ff.corner_b;
         default: cur_corner = req_ff.corner_c;
      endcase
      // corners are below MAX_VERTICES, so only vertex_count limits them
      corner_live = ({1'b0, cur_corner} < vcount_ff);

      case (step_ff)
         3'd0:    pos_raddr = req_ff.corner_a;
         3'd1:    pos_raddr = req_ff.corner_b;
         default: pos_raddr = req_ff.corner_c;
      endcase

      acc_raddr = (state_ff == ST_ARD) ? req_ff.vertex_index : cur_corner;

      for (int i = 0; i < 3; i++) begin
         acc_cur[i] = acc_rd_ff[(2-i)*ACC_W +: ACC_W];
      end

      pos_we = req_xfer && (req_payload.kind == KIND_WRITE);
      acc_we = (state_ff == ST_CLEAR) || (state_ff == ST_UWR);
      acc_waddr = (state_ff == ST_CLEAR) ? clr_addr_ff : cur_corner;
      if (state_ff == ST_CLEAR) begin
         acc_wdata = '0;
      end else begin
         acc_wdata = {sat_add(acc_cur[0], nrm_ff[0]),
                      sat_add(acc_cur[1], nrm_ff[1]),
                      sat_add(acc_cur[2], nrm_ff[2])};
      end
   end

   // ---- edges and multiplier operands ----
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         edge_val[i]   = {cpos_ff[1][i][POS_W-1], cpos_ff[1][i]}
                       - {cpos_ff[0][i][POS_W-1], cpos_ff[0][i]};
         edge_val[i+3] = {cpos_ff[2][i][POS_W-1], cpos_ff[2][i]}
                       - {cpos_ff[0][i][POS_W-1], cpos_ff[0][i]};
      end
      edge_big = 1'b0;
      for (int i = 0; i < 6; i++) begin
         edge_big  = edge_big | (|edge_mag_ff[i][EDGE_W-1:30]);
         edge_s[i] = edge_neg_ff[i] ? -$signed({1'b0, edge_mag_ff[i][29:0]})
                                    :  $signed({1'b0, edge_mag_ff[i][29:0]});
      end

      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_CROSS) begin
         case (step_ff)
            3'd0:    begin mul_a = edge_s[1]; mul_b = edge_s[5]; end
            3'd1:    begin mul_a = edge_s[2]; mul_b = edge_s[4]; end
            3'd2:    begin mul_a = edge_s[2]; mul_b = edge_s[3]; end
            3'd3:    begin mul_a = edge_s[0]; mul_b = edge_s[5]; end
            3'd4:    begin mul_a = edge_s[0]; mul_b = edge_s[4]; end
            3'd5:    begin mul_a = edge_s[1]; mul_b = edge_s[3]; end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else begin
         case (step_ff)
            3'd0: begin
               mul_a = $signed({1'b0, vec_mag_ff[0][29:0]});
               mul_b = mul_a;
            end
            3'd1: begin
               mul_a = $signed({1'b0, vec_mag_ff[1][29:0]});
               mul_b = mul_a;
            end
            3'd2: begin
               mul_a = $signed({1'b0, vec_mag_ff[2][29:0]});
               mul_b = mul_a;
            end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end

      cross_diff = cross_ff - {{(SQ_W-PROD_W){mul_ff[PROD_W-1]}}, mul_ff};
      cross_abs  = cross_diff[SQ_W-1] ? SQ_W'(-cross_diff) : SQ_W'(cross_diff);

      vec_or = vec_mag_ff[0] | vec_mag_ff[1] | vec_mag_ff[2];

      sqrt_trial = root_ff + bit_ff;
      sqrt_hit   = (rem_ff >= sqrt_trial);
      root_next  = sqrt_hit ? ((root_ff >> 1) + bit_ff) : (root_ff >> 1);

      div_trial = NUM_W'(len_ff) << qbit_ff;
      div_hit   = (num_ff >= div_trial);
      quo_next  = quo_ff | (div_hit ? (QUO_W'(1) << qbit_ff) : '0);

      case (comp_ff)
         2'd0:    begin comp_mag = vec_mag_ff[0]; comp_neg = vec_neg_ff[0]; end
         2'd1:    begin comp_mag = vec_mag_ff[1]; comp_neg = vec_neg_ff[1]; end
         default: begin comp_mag = vec_mag_ff[2]; comp_neg = vec_neg_ff[2]; end
      endcase
   end

   // ---- memories ----
   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[req_payload.vertex_index] <=
            {req_payload.pos_x, req_payload.pos_y, req_payload.pos_z};
      end
      pos_rd_ff <= pos_mem[pos_raddr];
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_waddr] <= acc_wdata;
      end
      acc_rd_ff <= acc_mem[acc_raddr];
   end

   // shared multiplier, one product a cycle
   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
   end

   // ---- sequencer ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         step_ff      <= '0;
         comp_ff      <= '0;
         vcount_ff    <= VCOUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            vcount_ff <= csr_data;
         end
         // the output step reloads the register itself
         if (rsp_ready && state_ff != ST_PUT) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (&clr_addr_ff) state_ff <= ST_IDLE;
            end

            ST_IDLE: begin
               step_ff <= '0;
               comp_ff <= '0;
               if (req_xfer) begin
                  req_ff <= req_payload;
                  case (req_payload.kind)
                     KIND_TRIANGLE: state_ff <= ST_FETCH;
                     KIND_READ:     state_ff <= ST_ARD;
                     KIND_CLEAR: begin
                        clr_addr_ff <= '0;
                        state_ff    <= ST_CLEAR;
                     end
                     default:       state_ff <= ST_IDLE;
                  endcase
               end
            end

            ST_FETCH: begin
               // read data is registered, so it arrives in the cycle after its address
               if (step_ff != 3'd0) begin
                  cpos_ff[2'(step_ff-3'd1)][0] <= pos_rd_ff[3*POS_W-1:2*POS_W];
                  cpos_ff[2'(step_ff-3'd1)][1] <= pos_rd_ff[2*POS_W-1:POS_W];
                  cpos_ff[2'(step_ff-3'd1)][2] <= pos_rd_ff[POS_W-1:0];
               end
               if (step_ff == 3'd3) begin
                  state_ff <= ST_EDGE;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end

            ST_EDGE: begin
               for (int i = 0; i < 6; i++) begin
                  edge_neg_ff[i] <= edge_val[i][EDGE_W-1];
                  edge_mag_ff[i] <= edge_val[i][EDGE_W-1] ? EDGE_W'(-edge_val[i])
                                                          : EDGE_W'(edge_val[i]);
               end
               state_ff <= ST_ESHIFT;
            end

            ST_ESHIFT: begin
               if (edge_big) begin
                  for (int i = 0; i < 6; i++) edge_mag_ff[i] <= edge_mag_ff[i] >> 1;
               end else begin
                  step_ff  <= '0;
                  state_ff <= ST_CROSS;
               end
            end

            ST_CROSS: begin
               // products alternate: first term, then subtract the second
               case (step_ff)
                  3'd1, 3'd3, 3'd5: begin
                     cross_ff <= {{(SQ_W-PROD_W){mul_ff[PROD_W-1]}}, mul_ff};
                  end
                  3'd2: begin
                     vec_mag_ff[0] <= cross_abs[VEC_W-1:0];
                     vec_neg_ff[0] <= cross_diff[SQ_W-1];
                  end
                  3'd4: begin
                     vec_mag_ff[1] <= cross_abs[VEC_W-1:0];
                     vec_neg_ff[1] <= cross_diff[SQ_W-1];
                  end
                  3'd6: begin
                     vec_mag_ff[2] <= cross_abs[VEC_W-1:0];
                     vec_neg_ff[2] <= cross_diff[SQ_W-1];
                  end
                  default: ;
               endcase
               if (step_ff == 3'd6) begin
                  state_ff <= ST_ZCHK;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end

            ST_ARD: state_ff <= ST_ALD;

            ST_ALD: begin
               // magnitude zero-extends, so the most negative sum reads as 2^23
               for (int i = 0; i < 3; i++) begin
                  vec_neg_ff[i] <= acc_cur[i][ACC_W-1];
                  vec_mag_ff[i] <= VEC_W'({acc_cur[i][ACC_W-1] ? ACC_W'(-acc_cur[i])
                                                              : ACC_W'(acc_cur[i])});
               end
               state_ff <= ST_ZCHK;
            end

            ST_ZCHK: begin
               if (vec_or == '0) begin
                  if (req_ff.kind == KIND_READ) begin
                     for (int i = 0; i < 3; i++) nrm_ff[i] <= '0;
                     degen_ff <= 1'b1;
                     state_ff <= ST_PUT;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end else begin
                  state_ff <= ST_NORM;
               end
            end

            ST_NORM: begin
               // bring the largest magnitude into [2^29, 2^30)
               step_ff <= '0;
               if (|vec_or[VEC_W-1:34]) begin
                  for (int i = 0; i < 3; i++) vec_mag_ff[i] <= vec_mag_ff[i] >> 4;
               end else if (|vec_or[33:30]) begin
                  for (int i = 0; i < 3; i++) vec_mag_ff[i] <= vec_mag_ff[i] >> 1;
               end else if (vec_or[29:25] == '0) begin
                  for (int i = 0; i < 3; i++) vec_mag_ff[i] <= vec_mag_ff[i] << 4;
               end else if (!vec_or[29]) begin
                  for (int i = 0; i < 3; i++) vec_mag_ff[i] <= vec_mag_ff[i] << 1;
               end else begin
                  rem_ff   <= '0;
                  state_ff <= ST_SQR;
               end
            end

            ST_SQR: begin
               if (step_ff != 3'd0) begin
                  rem_ff <= rem_ff + SQ_W'(unsigned'(mul_ff));
               end
               if (step_ff == 3'd3) begin
                  root_ff  <= '0;
                  bit_ff   <= SQ_W'(1) << 62;
                  state_ff <= ST_SQRT;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end

            ST_SQRT: begin
               if (sqrt_hit) rem_ff <= rem_ff - sqrt_trial;
               root_ff <= root_next;
               bit_ff  <= bit_ff >> 2;
               if (bit_ff[0]) begin
                  len_ff   <= root_next[LEN_W-1:0];
                  comp_ff  <= '0;
                  state_ff <= ST_DIVLD;
               end
            end

            ST_DIVLD: begin
               num_ff   <= {3'b0, comp_mag[29:0], 14'b0} + NUM_W'(len_ff >> 1);
               quo_ff   <= '0;
               qbit_ff  <= 4'(QUO_W - 1);
               state_ff <= ST_DIV;
            end

            ST_DIV: begin
               if (div_hit) num_ff <= num_ff - div_trial;
               quo_ff <= quo_next;
               if (qbit_ff == 4'd0) begin
                  nrm_ff[comp_ff] <= comp_neg ? -$signed({1'b0, quo_next})
                                              :  $signed({1'b0, quo_next});
                  if (comp_ff == 2'd2) begin
                     comp_ff  <= '0;
                     degen_ff <= 1'b0;
                     state_ff <= (req_ff.kind == KIND_READ) ? ST_PUT : ST_URD;
                  end else begin
                     comp_ff  <= comp_ff + 1'b1;
                     state_ff <= ST_DIVLD;
                  end
               end else begin
                  qbit_ff <= qbit_ff - 1'b1;
               end
            end

            ST_URD: begin
               if (corner_live) begin
                  state_ff <= ST_UWR;
               end else if (comp_ff == 2'd2) begin
                  state_ff <= ST_IDLE;
               end else begin
                  comp_ff <= comp_ff + 1'b1;
               end
            end

            ST_UWR: begin
               if (comp_ff == 2'd2) begin
                  state_ff <= ST_IDLE;
               end else begin
                  comp_ff  <= comp_ff + 1'b1;
                  state_ff <= ST_URD;
               end
            end

            ST_PUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_payload_ff.normal_x   <= nrm_ff[0];
                  rsp_payload_ff.normal_y   <= nrm_ff[1];
                  rsp_payload_ff.normal_z   <= nrm_ff[2];
                  rsp_payload_ff.degenerate <= degen_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTH
   a_rsp_from_put: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_PUT))
      else $error("response raised outside the output step");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQR && step_ff == 3'd0)
         |-> (vec_or[VEC_W-1:30] == '0 && vec_or[29]))
      else $error("normalized magnitude out of range");

   a_update_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UWR) |-> ({1'b0, cur_corner} < vcount_ff))
      else $error("accumulator update beyond vertex_count");

   a_result_read_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUT) |-> (req_ff.kind == KIND_READ))
      else $error("result produced for a non-read operation");
`endif

endmodule

`default_nettype wire
